// ----- hw/rtl/dwo_pkg.sv -----
// Shared types and constants of the dual wavetable oscillator.
package dwo_pkg;

  // Number of entries in each table.
  localparam int TABLE_DEPTH = 2048;

  // Fixed-point formats of the phase, the samples and the crossfade weight.
  localparam int FRAC_BITS   = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int MIX_BITS    = 16;

  // Widths of the configuration registers and of the request fields.
  localparam int STEP_W     = 27;
  localparam int SIZE_CFG_W = 12;
  localparam int MIX_CFG_W  = MIX_BITS + 1;
  localparam int CFG_DATA_W = 27;
  localparam int CFG_IDX_W  = 2;
  localparam int REQ_W      = 2;
  localparam int WADDR_W    = 11;

  // Reset value of the table size register, and the crossfade weight of one.
  localparam logic [SIZE_CFG_W-1:0] SIZE_RESET = 12'd2048;
  localparam logic [MIX_CFG_W-1:0]  MIX_ONE    = 17'h10000;

  // Request codes carried by req_type.
  typedef enum logic [REQ_W-1:0] {
    REQ_SAMPLE  = 2'd0,
    REQ_WRITE_A = 2'd1,
    REQ_WRITE_B = 2'd2
  } req_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_STEP = 2'd0,
    CFG_TABLE_SIZE = 2'd1,
    CFG_FADE_MIX   = 2'd2
  } cfg_idx_e;

  // Sequencer states of one sample request.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INTERP,
    ST_MIX
  } state_e;

  // Stage enables from the sequencer to the arithmetic datapath.
  typedef struct packed {
    logic interp_en;
    logic mix_en;
  } blend_ctrl_t;

endpackage

// ----- hw/rtl/dwo_ram.sv -----
// Generic RAM with one write port and two registered read ports.
module dwo_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic [WIDTH-1:0]         rdata0_o,
  output logic [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Both read ports register their data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata0_o <= mem_q[raddr0_i];
      rdata1_o <= mem_q[raddr1_i];
    end
  end

endmodule

// ----- hw/rtl/dwo_phase.sv -----
// Phase accumulator and table address generation.
module dwo_phase (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      advance_i,
  input  logic [dwo_pkg::STEP_W-1:0]                step_i,
  input  logic [$clog2(dwo_pkg::TABLE_DEPTH):0]     size_i,
  output logic [$clog2(dwo_pkg::TABLE_DEPTH)-1:0]   base_o,
  output logic [$clog2(dwo_pkg::TABLE_DEPTH)-1:0]   next_o,
  output logic [dwo_pkg::FRAC_BITS-1:0]             frac_o
);
  import dwo_pkg::*;

  localparam int AddrW = $clog2(TABLE_DEPTH);
  localparam int SizeW = AddrW + 1;
  localparam int PhW   = AddrW + FRAC_BITS;
  localparam int SpanW = PhW + 1;
  localparam int CmpW  = (STEP_W > SpanW) ? STEP_W : SpanW;

  logic [PhW-1:0]   phase_q, phase_d;
  logic [FRAC_BITS-1:0] frac_q;
  logic [SpanW-1:0] span;
  logic [SpanW-1:0] span_m1;
  logic [PhW-1:0]   phase_eff;
  logic [CmpW-1:0]  step_ext;
  logic [PhW-1:0]   step_c;
  logic [SpanW-1:0] sum;
  logic [SpanW-1:0] sum_wrap;
  logic [SizeW-1:0] base_inc;

  // Span of the table in phase units; a phase left beyond a shrunk table restarts at zero.
  always_comb begin
    span      = {size_i, {FRAC_BITS{1'b0}}};
    span_m1   = span - SpanW'(1);
    phase_eff = ({1'b0, phase_q} >= span) ? '0 : phase_q;
  end

  // Addresses of the entry pair and the fraction between them.
  always_comb begin
    base_o   = phase_eff[PhW-1:FRAC_BITS];
    base_inc = SizeW'(base_o) + SizeW'(1);
    next_o   = (base_inc >= size_i) ? '0 : base_inc[AddrW-1:0];
  end

  // Advance by the clamped step and wrap once at the span.
  always_comb begin
    step_ext = CmpW'(step_i);
    step_c   = (step_ext >= CmpW'(span)) ? span_m1[PhW-1:0] : step_ext[PhW-1:0];
    sum      = {1'b0, phase_eff} + {1'b0, step_c};
    sum_wrap = (sum >= span) ? (sum - span) : sum;
    phase_d  = sum_wrap[PhW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (advance_i) begin
      phase_q <= phase_d;
    end
  end

  // The fraction travels alongside the memory read.
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      frac_q <= phase_eff[FRAC_BITS-1:0];
    end
  end

  assign frac_o = frac_q;

endmodule

// ----- hw/rtl/dwo_blend.sv -----
// Interpolation of both tables and the crossfade into the output sample.
module dwo_blend (
  input  logic                                   clk_i,
  input  dwo_pkg::blend_ctrl_t                   ctrl_i,
  input  logic [dwo_pkg::FRAC_BITS-1:0]          frac_i,
  input  logic [dwo_pkg::MIX_CFG_W-1:0]          mix_i,
  input  logic signed [dwo_pkg::SAMPLE_BITS-1:0] a0_i,
  input  logic signed [dwo_pkg::SAMPLE_BITS-1:0] a1_i,
  input  logic signed [dwo_pkg::SAMPLE_BITS-1:0] b0_i,
  input  logic signed [dwo_pkg::SAMPLE_BITS-1:0] b1_i,
  output logic signed [dwo_pkg::SAMPLE_BITS-1:0] sample_o
);
  import dwo_pkg::*;

  localparam int S = SAMPLE_BITS;

  logic signed [S-1:0] s1_q, s2_q, y_q;

  // Linear interpolation by the phase fraction, rounded toward minus infinity.
  function automatic logic signed [S-1:0] lerp_frac(input logic signed [S-1:0] a,
                                                    input logic signed [S-1:0] b,
                                                    input logic [FRAC_BITS-1:0] w);
    logic signed [S:0]             diff;
    logic signed [S+FRAC_BITS+1:0] prod;
    logic signed [S+FRAC_BITS+1:0] acc;
    diff = {b[S-1], b} - {a[S-1], a};
    prod = diff * $signed({1'b0, w});
    acc  = $signed({{2{a[S-1]}}, a, {FRAC_BITS{1'b0}}}) + prod;
    return acc[FRAC_BITS +: S];
  endfunction

  // Crossfade by a Q16 weight that may reach one, rounded toward minus infinity.
  function automatic logic signed [S-1:0] lerp_mix(input logic signed [S-1:0] a,
                                                   input logic signed [S-1:0] b,
                                                   input logic [MIX_CFG_W-1:0] w);
    logic signed [S:0]            diff;
    logic signed [S+MIX_BITS+2:0] prod;
    logic signed [S+MIX_BITS+2:0] acc;
    diff = {b[S-1], b} - {a[S-1], a};
    prod = diff * $signed({1'b0, w});
    acc  = $signed({{3{a[S-1]}}, a, {MIX_BITS{1'b0}}}) + prod;
    return acc[MIX_BITS +: S];
  endfunction

  // First stage: one interpolation per table from the freshly read entries.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.interp_en) begin
      s1_q <= lerp_frac(a0_i, a1_i, frac_i);
      s2_q <= lerp_frac(b0_i, b1_i, frac_i);
    end
  end

  // Second stage: crossfade into the output register.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mix_en) begin
      y_q <= lerp_mix(s1_q, s2_q, mix_i);
    end
  end

  assign sample_o = y_q;

endmodule

// ----- hw/rtl/dual_wavetable_oscillator_core.sv -----
// Top level of the dual wavetable oscillator: configuration, sequencer and tables.
//
//   Channel  Direction  Handshake                    Payload
//   in       input      in_valid_i / in_ready_o      req_type_i, write_address_i, write_value_i
//   out      output     out_valid_o / out_ready_i    sample_o
//   cfg      input      cfg_we_i                     cfg_index_i, cfg_wdata_i
//
// Table writes can follow each other in every cycle while no sample request is in work.
// A sample request passes the registered table read, the two interpolations, then the
// crossfade into the output register; in_ready_o stays low from its transfer until the
// crossfade is loaded, so no new request is taken before the last one is through.
// A result waiting in the output register does not stop new transfers on the input;
// only a second sample finishing behind it holds in the crossfade stage.
// Reset clears the phase, the step and the crossfade weight and sets the table size to
// its reset value; table contents are undefined until written and need no clearing.
module dual_wavetable_oscillator_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [dwo_pkg::REQ_W-1:0]              req_type_i,
  input  logic [dwo_pkg::WADDR_W-1:0]            write_address_i,
  input  logic signed [dwo_pkg::SAMPLE_BITS-1:0] write_value_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [dwo_pkg::SAMPLE_BITS-1:0] sample_o,
  input  logic                                   cfg_we_i,
  input  logic [dwo_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [dwo_pkg::CFG_DATA_W-1:0]         cfg_wdata_i
);
  import dwo_pkg::*;

  localparam int AddrW = $clog2(TABLE_DEPTH);
  localparam int SizeW = AddrW + 1;
  localparam int CmpSW = SIZE_CFG_W + 1;

  // Clamp a table size to the range of the memory.
  function automatic logic [SizeW-1:0] clamp_size(input logic [SIZE_CFG_W-1:0] v);
    logic [CmpSW-1:0] ve;
    logic [CmpSW-1:0] r;
    ve = {1'b0, v};
    if (ve < CmpSW'(2)) begin
      r = CmpSW'(2);
    end else if (ve > CmpSW'(TABLE_DEPTH)) begin
      r = CmpSW'(TABLE_DEPTH);
    end else begin
      r = ve;
    end
    return r[SizeW-1:0];
  endfunction

  localparam logic [SizeW-1:0] SizeReset = clamp_size(SIZE_RESET);

  state_e state_q, state_d;
  logic [STEP_W-1:0]    step_q;
  logic [SizeW-1:0]     size_q;
  logic [MIX_CFG_W-1:0] mix_q;
  logic                 out_valid_q, out_valid_d;
  logic                 in_fire;
  logic                 sample_fire;
  logic                 addr_ok;
  logic                 we_a, we_b;
  logic                 out_load;
  blend_ctrl_t          ctrl;
  logic [AddrW-1:0]     base, next;
  logic [FRAC_BITS-1:0] frac;
  logic [SAMPLE_BITS-1:0] a0, a1, b0, b1;

  // Configuration registers; the table size and the crossfade weight are clamped before they are stored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      size_q <= SizeReset;
      mix_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_PHASE_STEP: step_q <= cfg_wdata_i[STEP_W-1:0];
        CFG_TABLE_SIZE: size_q <= clamp_size(cfg_wdata_i[SIZE_CFG_W-1:0]);
        CFG_FADE_MIX: begin
          mix_q <= (cfg_wdata_i[MIX_CFG_W-1:0] > MIX_ONE) ? MIX_ONE
                                                           : cfg_wdata_i[MIX_CFG_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // Decode of an input transfer.
  always_comb begin
    in_fire     = in_valid_i && in_ready_o;
    addr_ok     = ({1'b0, write_address_i} < (WADDR_W + 1)'(TABLE_DEPTH));
    sample_fire = 1'b0;
    we_a        = 1'b0;
    we_b        = 1'b0;
    unique case (req_e'(req_type_i))
      REQ_SAMPLE:  sample_fire = in_fire;
      REQ_WRITE_A: we_a        = in_fire && addr_ok;
      REQ_WRITE_B: we_b        = in_fire && addr_ok;
      default: ;
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (sample_fire) state_d = ST_INTERP;
      ST_INTERP: state_d = ST_MIX;
      ST_MIX:    if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready_o     = (state_q == ST_IDLE);
    ctrl.interp_en = (state_q == ST_INTERP);
    out_load       = (state_q == ST_MIX) && (!out_valid_q || out_ready_i);
    ctrl.mix_en    = out_load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Output register valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // Phase accumulator drives the read addresses in the cycle of the sample transfer.
  dwo_phase u_phase (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (sample_fire),
    .step_i    (step_q),
    .size_i    (size_q),
    .base_o    (base),
    .next_o    (next),
    .frac_o    (frac)
  );

  // Tables. A write and a sample read never share a transfer, and a write lands
  // before any later read is issued, so no forwarding is needed.
  dwo_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(TABLE_DEPTH)
  ) u_table_a (
    .clk_i    (clk_i),
    .we_i     (we_a),
    .waddr_i  (write_address_i[AddrW-1:0]),
    .wdata_i  (write_value_i),
    .re_i     (sample_fire),
    .raddr0_i (base),
    .raddr1_i (next),
    .rdata0_o (a0),
    .rdata1_o (a1)
  );

  dwo_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(TABLE_DEPTH)
  ) u_table_b (
    .clk_i    (clk_i),
    .we_i     (we_b),
    .waddr_i  (write_address_i[AddrW-1:0]),
    .wdata_i  (write_value_i),
    .re_i     (sample_fire),
    .raddr0_i (base),
    .raddr1_i (next),
    .rdata0_o (b0),
    .rdata1_o (b1)
  );

  // Interpolation and crossfade datapath.
  dwo_blend u_blend (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .frac_i   (frac),
    .mix_i    (mix_q),
    .a0_i     ($signed(a0)),
    .a1_i     ($signed(a1)),
    .b0_i     ($signed(b0)),
    .b1_i     ($signed(b1)),
    .sample_o (sample_o)
  );

endmodule

// ----- hw/rtl/dwo_checker.sv -----
// Port-level checks of the oscillator and their binding to the top level.
module dwo_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_valid_i,
  input logic                                   in_ready_o,
  input logic [dwo_pkg::REQ_W-1:0]              req_type_i,
  input logic                                   out_valid_o,
  input logic                                   out_ready_i,
  input logic signed [dwo_pkg::SAMPLE_BITS-1:0] sample_o
);
  import dwo_pkg::*;

  logic [1:0] pend_q;
  logic       in_smp;
  logic       in_wr;
  logic       out_xfer;

  // Count sample requests whose result has not yet been transferred.
  always_comb begin
    in_smp   = in_valid_i && in_ready_o && (req_type_i == REQ_SAMPLE);
    in_wr    = in_valid_i && in_ready_o && (req_type_i != REQ_SAMPLE);
    out_xfer = out_valid_o && out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_smp) - 2'(out_xfer);
    end
  end

  // A waiting result holds still until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sample_o))
    else $error("output result changed while stalled");

  // Every result answers an earlier sample request.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 2'd0)
    else $error("result without a pending sample request");

  // At most one sample in work and one waiting in the output register.
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("too many sample requests outstanding");

  // The input is held off only while a sample is being worked on.
  a_ready_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> pend_q != 2'd0)
    else $error("input held off with no sample outstanding");

  // Table writes never hold off the next transfer.
  a_write_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_wr |=> in_ready_o)
    else $error("table write stalled the input");

endmodule

bind dual_wavetable_oscillator_core dwo_checker u_checker (.*);
